[src/pwlti_pkg.sv]
// ----------------------------------------------------------------------------
// Piecewise-linear table interpolator package
// Shared types, sizes and codes for the interpolator core.
// ----------------------------------------------------------------------------
`default_nettype none

package pwlti_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned KeyBits    = 12;
  localparam int unsigned IdxBits    = $clog2(TableDepth);
  localparam int unsigned CntBits    = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLAMPED = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] key;
    logic [31:0] point_value;
    logic [31:0] fallback_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] estimate;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [31:0]        value;
  } entry_t;

endpackage : pwlti_pkg

`default_nettype wire

[src/pwlti_table_ram.sv]
// ----------------------------------------------------------------------------
// Breakpoint table memory
// Single-port synchronous memory holding one key and value per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pwlti_table_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [pwlti_pkg::IdxBits-1:0] addr_i,
  input  wire pwlti_pkg::entry_t        wdata_i,
  output pwlti_pkg::entry_t             rdata_o
);
  import pwlti_pkg::*;

  entry_t mem_q [TableDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule : pwlti_table_ram

`default_nettype wire

[src/pwlti_divider.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Divides a 44-bit magnitude by a key span, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwlti_divider (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [pwlti_pkg::KeyBits+31:0]   dividend_i,
  input  wire logic [pwlti_pkg::KeyBits-1:0]    divisor_i,
  output logic                                  done_o,
  output logic [pwlti_pkg::KeyBits+31:0]        quotient_o
);
  import pwlti_pkg::*;

  localparam int unsigned NumBits = KeyBits + 32;
  localparam int unsigned CntW    = $clog2(NumBits + 1);

  logic [NumBits-1:0] quo_q, quo_d;
  logic [KeyBits:0]   rem_q, rem_d;
  logic [KeyBits-1:0] div_q, div_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [KeyBits:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[KeyBits-1:0], quo_q[NumBits-1]};
    done_o = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CntW'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quotient_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

endmodule : pwlti_divider

`default_nettype wire

[src/piecewise_linear_table_interpolator_core.sv]
// ----------------------------------------------------------------------------
// Piecewise-linear table interpolator core
// Sorted breakpoint table with clamped linear interpolation between points.
// ----------------------------------------------------------------------------
// Items arrive on the in channel (in_valid_i, in_ready_o, in_item_i) and one
// result per item leaves on the out channel (out_valid_o, out_ready_i,
// out_item_o). Both channels move a transfer when valid and ready are high.
// The table lives in a single-port memory with a registered read port, and
// every item is handled by a sequencer that walks that port entry by entry.
// A load scans upwards to find its slot and shifts the later entries up one
// place. A query scans up to the first key not below the queried key, then
// reads the lower neighbour, multiplies and runs a restoring division. One
// item is in work at a time. A finished result waits in a holding register
// until the output register is free, and the next item is accepted only
// once it has moved there, so a stalled receiver holds at most two results
// before the input stops. Reset empties the table at once; no clearing pass
// is needed since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_interpolator_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire pwlti_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output pwlti_pkg::out_item_t      out_item_o
);
  import pwlti_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LSCAN   = 4'd1;
  localparam logic [3:0] S_LSHRD   = 4'd2;
  localparam logic [3:0] S_LCMP    = 4'd3;
  localparam logic [3:0] S_QSCAN   = 4'd4;
  localparam logic [3:0] S_QLOW    = 4'd5;
  localparam logic [3:0] S_QMUL    = 4'd6;
  localparam logic [3:0] S_QDIV    = 4'd7;
  localparam logic [3:0] S_RESULT  = 4'd8;
  localparam logic [3:0] S_QSTART  = 4'd9;
  localparam logic [3:0] S_LSHWR   = 4'd10;
  localparam logic [3:0] S_QDSTART = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [CntBits-1:0] count_q, count_d;
  logic [CntBits-1:0] idx_q, idx_d;
  logic [CntBits-1:0] pos_q, pos_d;
  in_item_t           item_q, item_d;
  entry_t             up_q, up_d;
  entry_t             hold_q, hold_d;
  logic [KeyBits+31:0] prod_q, prod_d;
  logic [KeyBits-1:0] span_q, span_d;
  logic               neg_q, neg_d;
  out_item_t          res_q, res_d;
  logic               res_pend_q, res_pend_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               ram_we;
  logic [IdxBits-1:0] ram_addr;
  entry_t             ram_wdata, ram_rdata;
  logic               div_start, div_done;
  logic [KeyBits+31:0] div_quo;
  logic [KeyBits-1:0] qkey;
  logic [31:0]        vdiff;
  logic [KeyBits-1:0] dk;

  pwlti_table_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  pwlti_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (span_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign qkey       = item_q.key[KeyBits-1:0];
  assign in_ready_o = (state_q == S_IDLE) && !res_pend_q;
  assign dk         = qkey - hold_q.key;
  assign vdiff      = neg_q ? (hold_q.value - up_q.value) : (up_q.value - hold_q.value);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    item_d      = item_q;
    up_d        = up_q;
    hold_d      = hold_q;
    prod_d      = prod_q;
    span_d      = span_q;
    neg_d       = neg_q;
    res_d       = res_q;
    res_pend_d  = res_pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_addr    = idx_q[IdxBits-1:0];
    ram_wdata   = hold_q;
    div_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_pend_q && !out_valid_d) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
      res_pend_d  = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          item_d = in_item_i;
          idx_d  = '0;
          res_d  = '0;
          case (cmd_e'(in_item_i.cmd))
            CMD_CLEAR: begin
              count_d = '0;
              state_d = S_RESULT;
            end
            CMD_LOAD: begin
              if (count_q == CntBits'(TableDepth)) begin
                res_d.status = ST_FULL;
                state_d      = S_RESULT;
              end else begin
                state_d = S_LSCAN;
              end
            end
            CMD_QUERY: begin
              if (count_q == '0) begin
                res_d.status   = ST_EMPTY;
                res_d.estimate = in_item_i.fallback_value;
                state_d        = S_RESULT;
              end else begin
                state_d = S_QSTART;
              end
            end
            default: state_d = S_RESULT;
          endcase
        end
      end
      // Read of entry idx is issued here; data arrives in the next state.
      S_LSCAN: begin
        if (idx_q == count_q) begin
          pos_d   = idx_q;
          state_d = S_LSHRD;
        end else begin
          state_d = S_LCMP;
        end
      end
      S_LCMP: begin
        if (ram_rdata.key > qkey) begin
          pos_d   = idx_q;
          idx_d   = count_q;
          state_d = S_LSHRD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_LSCAN;
        end
      end
      // Shift phase: idx is the destination slot, walking down to pos.
      S_LSHRD: begin
        if (idx_q == pos_q) begin
          ram_we    = 1'b1;
          ram_addr  = pos_q[IdxBits-1:0];
          ram_wdata = '{key: qkey, value: item_q.point_value};
          count_d   = count_q + 1'b1;
          state_d   = S_RESULT;
        end else begin
          ram_addr = IdxBits'(idx_q - 1'b1);
          state_d  = S_LSHWR;
        end
      end
      S_LSHWR: begin
        ram_we    = 1'b1;
        ram_addr  = idx_q[IdxBits-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_q - 1'b1;
        state_d   = S_LSHRD;
      end
      S_QSTART: begin
        state_d = S_QSCAN;
      end
      S_QSCAN: begin
        if (ram_rdata.key < qkey) begin
          if (idx_q + 1'b1 == count_q) begin
            res_d.status   = ST_CLAMPED;
            res_d.estimate = ram_rdata.value;
            state_d        = S_RESULT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_QSTART;
          end
        end else if (ram_rdata.key == qkey) begin
          res_d.estimate = ram_rdata.value;
          state_d        = S_RESULT;
        end else if (idx_q == '0) begin
          res_d.status   = ST_CLAMPED;
          res_d.estimate = ram_rdata.value;
          state_d        = S_RESULT;
        end else begin
          up_d     = ram_rdata;
          idx_d    = idx_q - 1'b1;
          ram_addr = IdxBits'(idx_q - 1'b1);
          state_d  = S_QLOW;
        end
      end
      S_QLOW: begin
        hold_d  = ram_rdata;
        neg_d   = (up_q.value < ram_rdata.value);
        span_d  = up_q.key - ram_rdata.key;
        state_d = S_QMUL;
      end
      S_QMUL: begin
        prod_d  = (KeyBits + 32)'(vdiff) * (KeyBits + 32)'(dk);
        state_d = S_QDSTART;
      end
      S_QDSTART: begin
        div_start = 1'b1;
        state_d   = S_QDIV;
      end
      S_QDIV: begin
        if (div_done) begin
          res_d.estimate = neg_q ? (hold_q.value - div_quo[31:0])
                                 : (hold_q.value + div_quo[31:0]);
          state_d        = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!res_pend_d) begin
          res_pend_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_pend_q  <= res_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    item_q <= item_d;
    up_q   <= up_d;
    hold_q <= hold_d;
    prod_q <= prod_d;
    span_q <= span_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule : piecewise_linear_table_interpolator_core

`default_nettype wire

[src/pwlti_checker.sv]
// ----------------------------------------------------------------------------
// Interpolator port checker
// Watches the ports of the interpolator core for handshake slips and for a
// non-zero estimate on a dropped load.
`default_nettype none

module pwlti_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire pwlti_pkg::in_item_t  in_item_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire pwlti_pkg::out_item_t out_item_o
);
  import pwlti_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Result changed while its transfer was pending.");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("Input item changed while its transfer was pending.");

  a_no_double_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input ready again straight after a transfer.");

  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_FULL) |-> out_item_o.estimate == '0)
    else $error("Dropped load returned a non-zero estimate.");

endmodule : pwlti_checker

bind piecewise_linear_table_interpolator_core pwlti_checker u_pwlti_checker (.*);

`default_nettype wire
